// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the neighbor list block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define HGN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Same-cycle check failed.");
`define HGN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Next-cycle check failed.");
`else
`define HGN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HGN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/hgn_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex grid neighbor list package
// Grid constants, cell classes, neighbor sources and the slot plan table.
// ----------------------------------------------------------------------------
package hgn_pkg;

  localparam int GridSide = 16;
  localparam int Slots    = 6;

  localparam logic [8:0] SideW   = 9'(GridSide);
  localparam logic [8:0] SideM1W = 9'(GridSide - 1);
  localparam logic [8:0] NbNone  = 9'h1FF;

  typedef enum logic [3:0] {
    NB_NONE,
    NB_LEFT,
    NB_RIGHT,
    NB_UP_L,
    NB_UP,
    NB_UP_R,
    NB_DN_L,
    NB_DN,
    NB_DN_R
  } nb_src_e;

  typedef enum logic [3:0] {
    CLS_OUTSIDE,
    CLS_TOP_LEFT,
    CLS_TOP_RIGHT,
    CLS_TOP_MID,
    CLS_BOT_LEFT_ODD,
    CLS_BOT_LEFT_EVEN,
    CLS_BOT_RIGHT_ODD,
    CLS_BOT_RIGHT_EVEN,
    CLS_BOT_MID_ODD,
    CLS_BOT_MID_EVEN,
    CLS_MID_LEFT_ODD,
    CLS_MID_LEFT_EVEN,
    CLS_MID_RIGHT_ODD,
    CLS_MID_RIGHT_EVEN,
    CLS_MID_ODD,
    CLS_MID_EVEN
  } cls_e;

  typedef struct packed {
    logic [8:0] left;
    logic [8:0] right;
    logic [8:0] up_l;
    logic [8:0] up;
    logic [8:0] up_r;
    logic [8:0] dn_l;
    logic [8:0] dn;
    logic [8:0] dn_r;
  } cand_t;

  typedef struct packed {
    logic [2:0]         count;
    nb_src_e [Slots-1:0] src;
  } slot_plan_t;

  function automatic slot_plan_t plan_of(cls_e cls);
    slot_plan_t p;
    p.count = 3'd0;
    for (int s = 0; s < Slots; s++) begin
      p.src[s] = NB_NONE;
    end
    case (cls)
      CLS_TOP_LEFT: begin
        p.count = 3'd2;
        p.src[0] = NB_RIGHT; p.src[1] = NB_DN;
      end
      CLS_TOP_RIGHT: begin
        p.count = 3'd3;
        p.src[0] = NB_LEFT; p.src[1] = NB_DN_L; p.src[2] = NB_DN;
      end
      CLS_TOP_MID: begin
        p.count = 3'd4;
        p.src[0] = NB_LEFT; p.src[1] = NB_DN_L; p.src[2] = NB_DN; p.src[3] = NB_RIGHT;
      end
      CLS_BOT_LEFT_ODD: begin
        p.count = 3'd3;
        p.src[0] = NB_UP; p.src[1] = NB_UP_R; p.src[2] = NB_RIGHT;
      end
      CLS_BOT_LEFT_EVEN: begin
        p.count = 3'd2;
        p.src[0] = NB_UP; p.src[1] = NB_RIGHT;
      end
      CLS_BOT_RIGHT_ODD: begin
        p.count = 3'd2;
        p.src[0] = NB_UP; p.src[1] = NB_LEFT;
      end
      CLS_BOT_RIGHT_EVEN: begin
        p.count = 3'd3;
        p.src[0] = NB_UP; p.src[1] = NB_UP_L; p.src[2] = NB_LEFT;
      end
      CLS_BOT_MID_ODD: begin
        p.count = 3'd4;
        p.src[0] = NB_LEFT; p.src[1] = NB_UP; p.src[2] = NB_UP_R; p.src[3] = NB_RIGHT;
      end
      CLS_BOT_MID_EVEN: begin
        p.count = 3'd4;
        p.src[0] = NB_LEFT; p.src[1] = NB_UP_L; p.src[2] = NB_UP; p.src[3] = NB_RIGHT;
      end
      CLS_MID_LEFT_ODD: begin
        p.count = 3'd5;
        p.src[0] = NB_UP; p.src[1] = NB_UP_R; p.src[2] = NB_RIGHT;
        p.src[3] = NB_DN_R; p.src[4] = NB_DN;
      end
      CLS_MID_LEFT_EVEN: begin
        p.count = 3'd3;
        p.src[0] = NB_UP; p.src[1] = NB_RIGHT; p.src[2] = NB_DN;
      end
      CLS_MID_RIGHT_ODD: begin
        p.count = 3'd3;
        p.src[0] = NB_UP; p.src[1] = NB_LEFT; p.src[2] = NB_DN;
      end
      CLS_MID_RIGHT_EVEN: begin
        p.count = 3'd5;
        p.src[0] = NB_UP; p.src[1] = NB_UP_L; p.src[2] = NB_LEFT;
        p.src[3] = NB_DN_L; p.src[4] = NB_DN;
      end
      CLS_MID_ODD: begin
        p.count = 3'd6;
        p.src[0] = NB_LEFT; p.src[1] = NB_UP; p.src[2] = NB_UP_R;
        p.src[3] = NB_RIGHT; p.src[4] = NB_DN_R; p.src[5] = NB_DN;
      end
      CLS_MID_EVEN: begin
        p.count = 3'd6;
        p.src[0] = NB_LEFT; p.src[1] = NB_UP_L; p.src[2] = NB_UP;
        p.src[3] = NB_RIGHT; p.src[4] = NB_DN; p.src[5] = NB_DN_L;
      end
      default: begin
        p.count = 3'd0;
      end
    endcase
    return p;
  endfunction

  function automatic logic [8:0] pick_nb(nb_src_e src, cand_t c);
    logic [8:0] v;
    case (src)
      NB_LEFT:  v = c.left;
      NB_RIGHT: v = c.right;
      NB_UP_L:  v = c.up_l;
      NB_UP:    v = c.up;
      NB_UP_R:  v = c.up_r;
      NB_DN_L:  v = c.dn_l;
      NB_DN:    v = c.dn;
      NB_DN_R:  v = c.dn_r;
      default:  v = NbNone;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/hgn_if.sv =====
// ----------------------------------------------------------------------------
// Hex grid neighbor list channels
// Valid/ready channels for cell requests and neighbor list results.
// ----------------------------------------------------------------------------
interface hgn_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_id;

  modport source (output valid, output cell_id, input ready);
  modport sink   (input valid, input cell_id, output ready);
endinterface

interface hgn_rsp_if;
  logic              valid;
  logic              ready;
  logic [2:0]        neighbor_count;
  logic signed [8:0] neighbor_a;
  logic signed [8:0] neighbor_b;
  logic signed [8:0] neighbor_c;
  logic signed [8:0] neighbor_d;
  logic signed [8:0] neighbor_e;
  logic signed [8:0] neighbor_f;

  modport source (output valid, output neighbor_count, output neighbor_a,
                  output neighbor_b, output neighbor_c, output neighbor_d,
                  output neighbor_e, output neighbor_f, input ready);
  modport sink   (input valid, input neighbor_count, input neighbor_a,
                  input neighbor_b, input neighbor_c, input neighbor_d,
                  input neighbor_e, input neighbor_f, output ready);
endinterface

// ===== sv/hex_grid_neighbor_list_core.sv =====
// A request accepted on the request channel is registered in stage one, stage two and
// stage three, which drives the result channel. Throughput: one request per cycle
// unless results stall; each of the three register stages advances on its own.
// A stalled result holds stage three, and earlier stages fill any empty slots behind it.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// Hex grid neighbor list core
// Splits a cell number into row and column, classifies the cell by edge and
// row parity, and returns the neighbor count and six neighbor slots.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hex_grid_neighbor_list_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  hgn_req_if.sink   req_i,
  hgn_rsp_if.source rsp_o
);
  import hgn_pkg::*;

  logic       v1_q, v2_q, v3_q;
  logic       adv1, adv2, adv3;

  logic [7:0] id_q, row_q, col_q;
  cls_e       cls_d, cls_q;
  cand_t      cand_d, cand_q;
  slot_plan_t plan;
  logic [2:0] cnt_q;
  logic [8:0] nb_d [Slots];
  logic [8:0] nb_q [Slots];

  logic [8:0] id9, row9, col9, up9, dn9;
  logic       top, bot, left, right, odd, outside;

  assign adv3 = !v3_q || rsp_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign req_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= req_i.valid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage one: split the cell number into row and column.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      id_q  <= req_i.cell_id;
      row_q <= 8'(req_i.cell_id / GridSide);
      col_q <= 8'(req_i.cell_id % GridSide);
    end
  end

  // Stage two: classify the cell and form every candidate neighbor number.
  always_comb begin
    id9  = {1'b0, id_q};
    row9 = {1'b0, row_q};
    col9 = {1'b0, col_q};
    up9  = id9 - SideW;
    dn9  = id9 + SideW;
    top     = (row_q == 8'd0);
    bot     = (row9 == SideM1W);
    left    = (col_q == 8'd0);
    right   = (col9 == SideM1W);
    odd     = row_q[0];
    outside = (row9 >= SideW);

    cand_d.left  = id9 - 9'd1;
    cand_d.right = id9 + 9'd1;
    cand_d.up_l  = up9 - 9'd1;
    cand_d.up    = up9;
    cand_d.up_r  = up9 + 9'd1;
    cand_d.dn_l  = dn9 - 9'd1;
    cand_d.dn    = dn9;
    cand_d.dn_r  = dn9 + 9'd1;

    if (outside) begin
      cls_d = CLS_OUTSIDE;
    end else if (top) begin
      cls_d = left ? CLS_TOP_LEFT : (right ? CLS_TOP_RIGHT : CLS_TOP_MID);
    end else if (bot) begin
      if (left) begin
        cls_d = odd ? CLS_BOT_LEFT_ODD : CLS_BOT_LEFT_EVEN;
      end else if (right) begin
        cls_d = odd ? CLS_BOT_RIGHT_ODD : CLS_BOT_RIGHT_EVEN;
      end else begin
        cls_d = odd ? CLS_BOT_MID_ODD : CLS_BOT_MID_EVEN;
      end
    end else if (left) begin
      cls_d = odd ? CLS_MID_LEFT_ODD : CLS_MID_LEFT_EVEN;
    end else if (right) begin
      cls_d = odd ? CLS_MID_RIGHT_ODD : CLS_MID_RIGHT_EVEN;
    end else begin
      cls_d = odd ? CLS_MID_ODD : CLS_MID_EVEN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      cls_q  <= cls_d;
      cand_q <= cand_d;
    end
  end

  // Stage three: fill the slots from the plan of the cell class.
  always_comb begin
    plan = plan_of(cls_q);
    for (int s = 0; s < Slots; s++) begin
      nb_d[s] = pick_nb(plan.src[s], cand_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      cnt_q <= plan.count;
      for (int s = 0; s < Slots; s++) begin
        nb_q[s] <= nb_d[s];
      end
    end
  end

  assign rsp_o.valid          = v3_q;
  assign rsp_o.neighbor_count = cnt_q;
  assign rsp_o.neighbor_a     = nb_q[0];
  assign rsp_o.neighbor_b     = nb_q[1];
  assign rsp_o.neighbor_c     = nb_q[2];
  assign rsp_o.neighbor_d     = nb_q[3];
  assign rsp_o.neighbor_e     = nb_q[4];
  assign rsp_o.neighbor_f     = nb_q[5];

  `HGN_ASSERT_NXT(a_req_enters, clk_i, rst_ni, req_i.valid && req_i.ready, v1_q)
  `HGN_ASSERT_IMP(a_count_legal, clk_i, rst_ni, v3_q, cnt_q != 3'd1 && cnt_q != 3'd7)
  `HGN_ASSERT_IMP(a_last_unused, clk_i, rst_ni, v3_q && cnt_q != 3'd6, nb_q[5] == NbNone)
  `HGN_ASSERT_IMP(a_none_empty, clk_i, rst_ni, v3_q && cnt_q == 3'd0, nb_q[0] == NbNone)

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Hex grid neighbor list testbench
// Sends cell number requests to the core through the valid/ready channels,
// predicts each neighbor list on the side and compares every result field
// by field, with random idle bursts on the request and the result channel.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hgn_pkg::*;

  typedef struct packed {
    logic [2:0]            count;
    logic [Slots-1:0][8:0] slot;
  } nb_list_t;

  typedef struct packed {
    logic [7:0] cell_num;
    logic       typed;
    nb_list_t   want;
  } dir_row_t;

  localparam int NumRandom = 600;
  localparam int CalmFrom  = 480;
  localparam int Limit     = 200000;
  localparam int DirRows   = 22;

  logic clk_i;
  logic rst_ni;

  hgn_req_if req_if ();
  hgn_rsp_if rsp_if ();

  hex_grid_neighbor_list_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  nb_list_t exp_lists [$];
  string    slot_name [Slots] = '{"neighbor_a", "neighbor_b", "neighbor_c",
                                  "neighbor_d", "neighbor_e", "neighbor_f"};
  int       n_fail    = 0;
  int       n_checked = 0;
  int       n_sent    = 0;
  int       cycles    = 0;
  bit       calm      = 1'b0;
  dir_row_t dir_tab [DirRows];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic nb_list_t list_of(int n, int a, int b, int c, int d, int e, int f);
    nb_list_t r;
    r.count   = 3'(n);
    r.slot[0] = 9'(a);
    r.slot[1] = 9'(b);
    r.slot[2] = 9'(c);
    r.slot[3] = 9'(d);
    r.slot[4] = 9'(e);
    r.slot[5] = 9'(f);
    return r;
  endfunction

  // Neighbors in slot order for offset rows, odd rows shifted right.
  function automatic nb_list_t hex_neighbors(logic [7:0] cell_num);
    int       id;
    int       row;
    int       col;
    int       up;
    int       dn;
    bit       odd;
    int       nbrs [$];
    nb_list_t r;
    id  = int'(cell_num);
    row = id / GridSide;
    col = id % GridSide;
    up  = id - GridSide;
    dn  = id + GridSide;
    odd = row[0];
    if (row >= GridSide) begin
      nbrs = {};
    end else if (row == 0) begin
      if (col == 0) begin
        nbrs = {id + 1, dn};
      end else if (col == GridSide - 1) begin
        nbrs = {id - 1, dn - 1, dn};
      end else begin
        nbrs = {id - 1, dn - 1, dn, id + 1};
      end
    end else if (row == GridSide - 1) begin
      if (col == 0) begin
        if (odd) begin
          nbrs = {up, up + 1, id + 1};
        end else begin
          nbrs = {up, id + 1};
        end
      end else if (col == GridSide - 1) begin
        if (odd) begin
          nbrs = {up, id - 1};
        end else begin
          nbrs = {up, up - 1, id - 1};
        end
      end else if (odd) begin
        nbrs = {id - 1, up, up + 1, id + 1};
      end else begin
        nbrs = {id - 1, up - 1, up, id + 1};
      end
    end else if (col == 0) begin
      if (odd) begin
        nbrs = {up, up + 1, id + 1, dn + 1, dn};
      end else begin
        nbrs = {up, id + 1, dn};
      end
    end else if (col == GridSide - 1) begin
      if (odd) begin
        nbrs = {up, id - 1, dn};
      end else begin
        nbrs = {up, up - 1, id - 1, dn - 1, dn};
      end
    end else if (odd) begin
      nbrs = {id - 1, up, up + 1, id + 1, dn + 1, dn};
    end else begin
      nbrs = {id - 1, up - 1, up, id + 1, dn, dn - 1};
    end
    r.count = 3'(nbrs.size());
    for (int j = 0; j < Slots; j++) begin
      r.slot[j] = (j < nbrs.size()) ? 9'(nbrs[j]) : NbNone;
    end
    return r;
  endfunction

  task automatic send_cell(input logic [7:0] cell_num, input logic typed, input nb_list_t want);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.cell_id <= cell_num;
    do @(posedge clk_i); while (!req_if.ready);
    exp_lists.push_back(typed ? want : hex_neighbors(cell_num));
    n_sent++;
  endtask

  task automatic check_list(input nb_list_t got);
    nb_list_t want;
    if (exp_lists.size() == 0) begin
      $error("Result with no request outstanding: neighbor_count %0d", got.count);
      n_fail++;
    end else begin
      want = exp_lists.pop_front();
      n_checked++;
      if (got.count !== want.count) begin
        $error("neighbor_count: expected %0d, got %0d", want.count, got.count);
        n_fail++;
      end
      for (int j = 0; j < Slots; j++) begin
        if (got.slot[j] !== want.slot[j]) begin
          $error("%s: expected %0d, got %0d", slot_name[j],
                 $signed(want.slot[j]), $signed(got.slot[j]));
          n_fail++;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      check_list({rsp_if.neighbor_count, rsp_if.neighbor_f, rsp_if.neighbor_e,
                  rsp_if.neighbor_d, rsp_if.neighbor_c, rsp_if.neighbor_b,
                  rsp_if.neighbor_a});
    end
  end

  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 10);
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    while (cycles < Limit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int row;
    int col;
    logic [7:0] cell_num;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.cell_id <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corners have their lists typed in; the other classes go through the predictor.
    dir_tab = '{
      '{8'd0,   1'b1, list_of(2, 1, 16, -1, -1, -1, -1)},
      '{8'd15,  1'b1, list_of(3, 14, 30, 31, -1, -1, -1)},
      '{8'd240, 1'b1, list_of(3, 224, 225, 241, -1, -1, -1)},
      '{8'd255, 1'b1, list_of(2, 239, 254, -1, -1, -1, -1)},
      '{8'd1,   1'b0, '0},
      '{8'd7,   1'b0, '0},
      '{8'd14,  1'b0, '0},
      '{8'd16,  1'b0, '0},
      '{8'd17,  1'b0, '0},
      '{8'd31,  1'b0, '0},
      '{8'd32,  1'b0, '0},
      '{8'd33,  1'b0, '0},
      '{8'd47,  1'b0, '0},
      '{8'd48,  1'b0, '0},
      '{8'd100, 1'b0, '0},
      '{8'd119, 1'b0, '0},
      '{8'd128, 1'b0, '0},
      '{8'd224, 1'b0, '0},
      '{8'd241, 1'b0, '0},
      '{8'd254, 1'b0, '0},
      '{8'hAA,  1'b0, '0},
      '{8'h55,  1'b0, '0}
    };
    foreach (dir_tab[r]) begin
      send_cell(dir_tab[r].cell_num, dir_tab[r].typed, dir_tab[r].want);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        // Let the pipeline drain completely before the next request.
        req_if.valid <= 1'b0;
        do @(posedge clk_i); while (exp_lists.size() != 0);
      end
      calm = (n >= CalmFrom);
      case ($urandom_range(0, 3))
        0: begin
          row = $urandom_range(0, 1) * (GridSide - 1);
          col = $urandom_range(0, GridSide - 1);
          cell_num = 8'(row * GridSide + col);
        end
        1: begin
          row = $urandom_range(0, GridSide - 1);
          col = $urandom_range(0, 1) * (GridSide - 1);
          cell_num = 8'(row * GridSide + col);
        end
        default: cell_num = 8'($urandom);
      endcase
      send_cell(cell_num, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    while (exp_lists.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d cell requests covering corners, edges and interior cells of both",
             n_sent);
    $display("row parities; checked %0d neighbor lists under random stalls on both sides.",
             n_checked);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
